[rtl/mept_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mept_pkg
// Shared sizes, entry layout and status codes of the mesh edge pairing table.
// ----------------------------------------------------------------------------
package mept_pkg;

    localparam int MAX_EDGES    = 1024;
    localparam int MAX_VERTICES = 1024;

    localparam int EDGE_AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int EDGE_CW = $clog2(MAX_EDGES + 1);
    localparam int VTX_AW  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;

    localparam int VTX_W   = 10;
    localparam int POLY_W  = 12;
    localparam int SIDE_W  = 4;
    localparam int IDX_W   = 10;
    localparam int COUNT_W = 16;
    localparam int OWN_W   = 2;

    typedef enum logic [2:0] {
        ST_NEW       = 3'd0,
        ST_PAIRED    = 3'd1,
        ST_SAME_DIR  = 3'd2,
        ST_SAME_POLY = 3'd3,
        ST_THIRD     = 3'd4,
        ST_FULL      = 3'd5
    } status_t;

    typedef struct packed {
        logic [VTX_W-1:0]  start_vtx;
        logic [VTX_W-1:0]  end_vtx;
        logic [POLY_W-1:0] first_poly;
        logic [SIDE_W-1:0] first_side;
        logic [POLY_W-1:0] second_poly;
        logic [SIDE_W-1:0] second_side;
        logic [OWN_W-1:0]  owners;
    } edge_entry_t;

    typedef struct packed {
        logic               en;
        logic [EDGE_AW-1:0] addr;
        edge_entry_t        data;
    } edge_wr_t;

    typedef struct packed {
        logic               rd_en;
        logic [VTX_AW-1:0]  rd_addr;
        logic               wr_en;
        logic [VTX_AW-1:0]  wr_addr;
        logic [COUNT_W-1:0] wr_data;
        logic               clear;
    } vtx_req_t;

endpackage

[rtl/mesh_edge_pairing_table_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mesh_edge_pairing_table_top
// Edge adjacency builder: pairs directed polygon sides into shared edges.
// ----------------------------------------------------------------------------
// Add side: the edge walk reads one stored edge per cycle and stops at the
//   first match; the decision then registers the result, waiting while a
//   held result still fills the result slot. One side is taken at a time.
// Clear: the decision registers the result, then a sweep zeroes every count.
// Reset: edge table empty; a sweep zeroes the vertex counts,
//   input stalled until it ends.
// ----------------------------------------------------------------------------
module mesh_edge_pairing_table_top
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         side_valid,
    output logic         side_stall,
    input  logic         cmd,
    input  logic [9:0]   vertex_from,
    input  logic [9:0]   vertex_to,
    input  logic [11:0]  polygon_id,
    input  logic [3:0]   side_index,
    output logic         result_valid,
    input  logic         result_stall,
    output logic [2:0]   status,
    output logic [9:0]   edge_index,
    output logic         owner_rank,
    output logic [15:0]  vertex_use_count
);

    logic                          edge_rd_en;
    logic [mept_pkg::EDGE_AW-1:0]  edge_rd_addr;
    mept_pkg::edge_entry_t         edge_rd_data;
    mept_pkg::edge_wr_t            edge_wr;
    mept_pkg::vtx_req_t            vtx_req;
    logic [mept_pkg::COUNT_W-1:0]  vtx_rd_data;
    logic                          vtx_busy;

    mept_edge_ram u_edge_ram
    (
        .clk     (clk),
        .rd_en   (edge_rd_en),
        .rd_addr (edge_rd_addr),
        .wr      (edge_wr),
        .rd_data (edge_rd_data)
    );

    mept_vertex_count u_vertex_count
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (vtx_req),
        .rd_data (vtx_rd_data),
        .busy    (vtx_busy)
    );

    mept_ctrl u_ctrl
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .side_valid       (side_valid),
        .side_stall       (side_stall),
        .cmd              (cmd),
        .vertex_from      (vertex_from),
        .vertex_to        (vertex_to),
        .polygon_id       (polygon_id),
        .side_index       (side_index),
        .result_valid     (result_valid),
        .result_stall     (result_stall),
        .status           (status),
        .edge_index       (edge_index),
        .owner_rank       (owner_rank),
        .vertex_use_count (vertex_use_count),
        .edge_rd_en       (edge_rd_en),
        .edge_rd_addr     (edge_rd_addr),
        .edge_rd_data     (edge_rd_data),
        .edge_wr          (edge_wr),
        .vtx_req          (vtx_req),
        .vtx_rd_data      (vtx_rd_data),
        .vtx_busy         (vtx_busy)
    );

endmodule

[rtl/mept_edge_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mept_edge_ram
// Edge table storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mept_edge_ram
(
    input  logic                          clk,
    input  logic                          rd_en,
    input  logic [mept_pkg::EDGE_AW-1:0]  rd_addr,
    input  mept_pkg::edge_wr_t            wr,
    output mept_pkg::edge_entry_t         rd_data
);

    mept_pkg::edge_entry_t edge_mem [mept_pkg::MAX_EDGES];
    mept_pkg::edge_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            edge_mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            rd_data_reg <= edge_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/mept_vertex_count.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mept_vertex_count
// Vertex use counts in one memory, with a zeroing sweep after reset and on
// a clear request.
// ----------------------------------------------------------------------------
module mept_vertex_count
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  mept_pkg::vtx_req_t            req,
    output logic [mept_pkg::COUNT_W-1:0]  rd_data,
    output logic                          busy
);

    logic [mept_pkg::COUNT_W-1:0] count_mem [mept_pkg::MAX_VERTICES];
    logic [mept_pkg::COUNT_W-1:0] rd_data_reg;
    logic                         busy_reg;
    logic                         busy_next;
    logic [mept_pkg::VTX_AW-1:0]  sweep_reg;
    logic [mept_pkg::VTX_AW-1:0]  sweep_next;

    localparam logic [mept_pkg::VTX_AW-1:0] LAST_ADDR =
        mept_pkg::VTX_AW'(mept_pkg::MAX_VERTICES - 1);

    always_comb
    begin
        busy_next  = busy_reg;
        sweep_next = sweep_reg;
        if (req.clear)
        begin
            busy_next  = 1'b1;
            sweep_next = '0;
        end
        else if (busy_reg)
        begin
            sweep_next = sweep_reg + 1'b1;
            if (sweep_reg == LAST_ADDR)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b1;
            sweep_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            sweep_reg <= sweep_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            count_mem[sweep_reg] <= '0;
        end
        else if (req.wr_en)
        begin
            count_mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= count_mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = busy_reg;

endmodule

[rtl/mept_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mept_ctrl
// Sequencer: walks the edge table for a match, decides the outcome, writes
// back the edge and the vertex count, and holds the result register.
// ----------------------------------------------------------------------------
module mept_ctrl
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          side_valid,
    output logic                          side_stall,
    input  logic                          cmd,
    input  logic [mept_pkg::VTX_W-1:0]    vertex_from,
    input  logic [mept_pkg::VTX_W-1:0]    vertex_to,
    input  logic [mept_pkg::POLY_W-1:0]   polygon_id,
    input  logic [mept_pkg::SIDE_W-1:0]   side_index,
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic [2:0]                    status,
    output logic [mept_pkg::IDX_W-1:0]    edge_index,
    output logic                          owner_rank,
    output logic [mept_pkg::COUNT_W-1:0]  vertex_use_count,
    output logic                          edge_rd_en,
    output logic [mept_pkg::EDGE_AW-1:0]  edge_rd_addr,
    input  mept_pkg::edge_entry_t         edge_rd_data,
    output mept_pkg::edge_wr_t            edge_wr,
    output mept_pkg::vtx_req_t            vtx_req,
    input  logic [mept_pkg::COUNT_W-1:0]  vtx_rd_data,
    input  logic                          vtx_busy
);

    typedef enum logic [1:0] {
        IDLE,
        SEARCH,
        DECIDE
    } state_t;

    localparam logic [mept_pkg::EDGE_CW-1:0] EDGE_LIMIT =
        mept_pkg::EDGE_CW'(mept_pkg::MAX_EDGES);

    state_t                        state_reg, state_next;
    logic                          cmd_reg, cmd_next;
    logic [mept_pkg::VTX_W-1:0]    from_reg, from_next;
    logic [mept_pkg::VTX_W-1:0]    to_reg, to_next;
    logic [mept_pkg::POLY_W-1:0]   poly_reg, poly_next;
    logic [mept_pkg::SIDE_W-1:0]   side_reg, side_next;
    logic [mept_pkg::EDGE_CW-1:0]  total_reg, total_next;
    logic [mept_pkg::EDGE_CW-1:0]  issue_reg, issue_next;
    logic                          pend_reg, pend_next;
    logic [mept_pkg::EDGE_AW-1:0]  pend_idx_reg, pend_idx_next;
    logic                          found_reg, found_next;
    logic                          rev_reg, rev_next;
    logic [mept_pkg::EDGE_AW-1:0]  hit_idx_reg, hit_idx_next;
    mept_pkg::edge_entry_t         hit_reg, hit_next;
    logic                          rvalid_reg, rvalid_next;
    mept_pkg::status_t             rstatus_reg, rstatus_next;
    logic [mept_pkg::IDX_W-1:0]    ridx_reg, ridx_next;
    logic                          rdir_reg, rdir_next;
    logic [mept_pkg::COUNT_W-1:0]  rcount_reg, rcount_next;

    logic                          accept;
    logic                          same_hit;
    logic                          rev_hit;
    logic                          slot_free;
    logic                          counted;
    logic [mept_pkg::COUNT_W-1:0]  count_now;
    logic [mept_pkg::COUNT_W-1:0]  count_inc;
    logic                          ok;
    mept_pkg::edge_entry_t         new_entry;

    assign side_stall = (state_reg != IDLE) || vtx_busy;
    assign accept     = side_valid && !side_stall;
    assign slot_free  = !rvalid_reg || !result_stall;

    assign same_hit = pend_reg && (edge_rd_data.start_vtx == from_reg)
                               && (edge_rd_data.end_vtx == to_reg);
    assign rev_hit  = pend_reg && (edge_rd_data.start_vtx == to_reg)
                               && (edge_rd_data.end_vtx == from_reg);

    assign counted   = int'(from_reg) < mept_pkg::MAX_VERTICES;
    assign count_now = counted ? vtx_rd_data : '0;
    assign count_inc = (count_now == '1) ? count_now : count_now + 1'b1;

    always_comb
    begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        from_next     = from_reg;
        to_next       = to_reg;
        poly_next     = poly_reg;
        side_next     = side_reg;
        total_next    = total_reg;
        issue_next    = issue_reg;
        pend_next     = 1'b0;
        pend_idx_next = pend_idx_reg;
        found_next    = found_reg;
        rev_next      = rev_reg;
        hit_idx_next  = hit_idx_reg;
        hit_next      = hit_reg;
        rvalid_next   = rvalid_reg && result_stall;
        rstatus_next  = rstatus_reg;
        ridx_next     = ridx_reg;
        rdir_next     = rdir_reg;
        rcount_next   = rcount_reg;
        ok            = 1'b0;

        edge_rd_en   = 1'b0;
        edge_rd_addr = issue_reg[mept_pkg::EDGE_AW-1:0];
        edge_wr      = '0;
        vtx_req      = '0;
        vtx_req.rd_addr = mept_pkg::VTX_AW'(vertex_from);
        vtx_req.wr_addr = mept_pkg::VTX_AW'(from_reg);
        vtx_req.wr_data = count_inc;

        new_entry             = hit_reg;
        new_entry.second_poly = poly_reg;
        new_entry.second_side = side_reg;
        new_entry.owners      = mept_pkg::OWN_W'(2);

        unique case (state_reg)
            IDLE:
            begin
                if (accept)
                begin
                    cmd_next   = cmd;
                    from_next  = vertex_from;
                    to_next    = vertex_to;
                    poly_next  = polygon_id;
                    side_next  = side_index;
                    issue_next = '0;
                    found_next = 1'b0;
                    rev_next   = 1'b0;
                    if (cmd)
                    begin
                        state_next = DECIDE;
                    end
                    else
                    begin
                        vtx_req.rd_en = 1'b1;
                        state_next    = SEARCH;
                    end
                end
            end
            SEARCH:
            begin
                if (same_hit || rev_hit)
                begin
                    // first matching edge decides; same direction wins
                    found_next   = 1'b1;
                    rev_next     = !same_hit;
                    hit_idx_next = pend_idx_reg;
                    hit_next     = edge_rd_data;
                    state_next   = DECIDE;
                end
                else if (issue_reg < total_reg)
                begin
                    edge_rd_en    = 1'b1;
                    pend_next     = 1'b1;
                    pend_idx_next = issue_reg[mept_pkg::EDGE_AW-1:0];
                    issue_next    = issue_reg + 1'b1;
                end
                else
                begin
                    state_next = DECIDE;
                end
            end
            DECIDE:
            begin
                if (slot_free)
                begin
                    rvalid_next = 1'b1;
                    ridx_next   = '0;
                    rdir_next   = 1'b0;
                    state_next  = IDLE;
                    if (cmd_reg)
                    begin
                        total_next    = '0;
                        vtx_req.clear = 1'b1;
                        rstatus_next  = mept_pkg::ST_NEW;
                        rcount_next   = '0;
                    end
                    else
                    begin
                        if (found_reg && !rev_reg)
                        begin
                            rstatus_next = mept_pkg::ST_SAME_DIR;
                        end
                        else if (found_reg)
                        begin
                            if (hit_reg.first_poly == poly_reg)
                            begin
                                rstatus_next = mept_pkg::ST_SAME_POLY;
                            end
                            else if (hit_reg.owners > mept_pkg::OWN_W'(1))
                            begin
                                rstatus_next = mept_pkg::ST_THIRD;
                            end
                            else
                            begin
                                ok           = 1'b1;
                                edge_wr.en   = 1'b1;
                                edge_wr.addr = hit_idx_reg;
                                edge_wr.data = new_entry;
                                rstatus_next = mept_pkg::ST_PAIRED;
                                ridx_next    = mept_pkg::IDX_W'(hit_idx_reg);
                                rdir_next    = 1'b1;
                            end
                        end
                        else if (total_reg >= EDGE_LIMIT)
                        begin
                            rstatus_next = mept_pkg::ST_FULL;
                        end
                        else
                        begin
                            // append a fresh edge with one owner
                            ok           = 1'b1;
                            edge_wr.en   = 1'b1;
                            edge_wr.addr = total_reg[mept_pkg::EDGE_AW-1:0];
                            edge_wr.data.start_vtx   = from_reg;
                            edge_wr.data.end_vtx     = to_reg;
                            edge_wr.data.first_poly  = poly_reg;
                            edge_wr.data.first_side  = side_reg;
                            edge_wr.data.second_poly = '0;
                            edge_wr.data.second_side = '0;
                            edge_wr.data.owners      = mept_pkg::OWN_W'(1);
                            total_next   = total_reg + 1'b1;
                            rstatus_next = mept_pkg::ST_NEW;
                            ridx_next    = mept_pkg::IDX_W'(total_reg);
                        end
                        vtx_req.wr_en = ok && counted;
                        rcount_next   = (ok && counted) ? count_inc : count_now;
                    end
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= IDLE;
            total_reg    <= '0;
            issue_reg    <= '0;
            pend_reg     <= 1'b0;
            found_reg    <= 1'b0;
            rev_reg      <= 1'b0;
            cmd_reg      <= 1'b0;
            rvalid_reg   <= 1'b0;
            from_reg     <= '0;
            to_reg       <= '0;
            poly_reg     <= '0;
            side_reg     <= '0;
            pend_idx_reg <= '0;
            hit_idx_reg  <= '0;
            hit_reg      <= '0;
            rstatus_reg  <= mept_pkg::ST_NEW;
            ridx_reg     <= '0;
            rdir_reg     <= 1'b0;
            rcount_reg   <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            total_reg    <= total_next;
            issue_reg    <= issue_next;
            pend_reg     <= pend_next;
            found_reg    <= found_next;
            rev_reg      <= rev_next;
            cmd_reg      <= cmd_next;
            rvalid_reg   <= rvalid_next;
            from_reg     <= from_next;
            to_reg       <= to_next;
            poly_reg     <= poly_next;
            side_reg     <= side_next;
            pend_idx_reg <= pend_idx_next;
            hit_idx_reg  <= hit_idx_next;
            hit_reg      <= hit_next;
            rstatus_reg  <= rstatus_next;
            ridx_reg     <= ridx_next;
            rdir_reg     <= rdir_next;
            rcount_reg   <= rcount_next;
        end
    end

    assign result_valid     = rvalid_reg;
    assign status           = rstatus_reg;
    assign edge_index       = ridx_reg;
    assign owner_rank       = rdir_reg;
    assign vertex_use_count = rcount_reg;

    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= EDGE_LIMIT)
        else $error("edge total beyond table size");

    a_sweep_stall: assert property (@(posedge clk) disable iff (!rst_n)
        vtx_busy |-> side_stall)
        else $error("side taken during count sweep");

    a_wr_decide: assert property (@(posedge clk) disable iff (!rst_n)
        edge_wr.en |-> (state_reg == DECIDE) && !cmd_reg && slot_free)
        else $error("edge write outside decision");

    a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == SEARCH) |-> (issue_reg <= total_reg))
        else $error("search ran past stored edges");

    a_clear_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        vtx_req.clear |=> vtx_busy)
        else $error("clear did not start count sweep");

endmodule

[verif/tb_mesh_edge_pairing_table_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mesh_edge_pairing_table_top
// Self-checking bench for the mesh edge pairing table. A short table of directed sides
// covers pairing, every error status but ST_FULL and the clear command. Random polygons
// over small vertex pools follow, then one full-table fill. Every result is compared
// against a behavioral edge table in the bench; hand-checked drill rows to golden values.
// ----------------------------------------------------------------------------
module tb_mesh_edge_pairing_table_top;

    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    localparam int N_DRILL        = 17;
    localparam int POOL_SIZE      = 12;
    localparam int HOLDOFF_CYCLES = 600;
    localparam int SETTLE_CYCLES  = 1100;
    localparam int CYCLE_LIMIT    = 20_000_000;

    typedef struct packed {
        logic        op;
        logic [9:0]  from_vtx;
        logic [9:0]  to_vtx;
        logic [11:0] poly;
        logic [3:0]  side;
    } side_item_t;

    typedef struct packed {
        mept_pkg::status_t code;
        logic [9:0]        edge_idx;
        logic              dir;
        logic [15:0]       uses;
    } outcome_t;

    typedef struct packed {
        side_item_t item;
        logic       hand_checked;
        outcome_t   golden;
    } drill_row_t;

    typedef struct packed {
        logic [9:0]  start_vtx;
        logic [9:0]  end_vtx;
        logic [11:0] first_poly;
        logic [3:0]  first_side;
        logic [11:0] second_poly;
        logic [3:0]  second_side;
        logic [1:0]  owners;
    } stored_edge_t;

    logic        clk;
    logic        rst_n;
    logic        side_valid;
    logic        side_stall;
    logic        cmd;
    logic [9:0]  vertex_from;
    logic [9:0]  vertex_to;
    logic [11:0] polygon_id;
    logic [3:0]  side_index;
    logic        result_valid;
    logic        result_stall;
    logic [2:0]  status;
    logic [9:0]  edge_index;
    logic        owner_rank;
    logic [15:0] vertex_use_count;

    stored_edge_t edge_tbl [mept_pkg::MAX_EDGES];
    int           edges_held = 0;
    logic [15:0]  vertex_uses [mept_pkg::MAX_VERTICES];

    outcome_t     pending_outcomes [$];
    drill_row_t   drill [N_DRILL];
    logic [9:0]   vtx_pool [POOL_SIZE];
    logic [11:0]  last_poly = '0;
    int           clear_at = 0;

    int           send_idle_pct = 0;
    int           recv_idle_pct = 0;
    int           holdoff_asked = 0;
    int           holdoff_served = 0;
    int           holdoff_left = 0;
    int           mismatches = 0;
    int           results_seen = 0;
    int unsigned  cycle_count;

    mesh_edge_pairing_table_top dut
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .side_valid       (side_valid),
        .side_stall       (side_stall),
        .cmd              (cmd),
        .vertex_from      (vertex_from),
        .vertex_to        (vertex_to),
        .polygon_id       (polygon_id),
        .side_index       (side_index),
        .result_valid     (result_valid),
        .result_stall     (result_stall),
        .status           (status),
        .edge_index       (edge_index),
        .owner_rank       (owner_rank),
        .vertex_use_count (vertex_use_count)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Walk the stored edges in index order; the first edge that matches either way decides.
    function automatic outcome_t resolve_side(input side_item_t it);
        outcome_t res;
        bit       found;
        bit       won;
        int       e;
        res = '0;
        res.code = mept_pkg::ST_NEW;
        found = 1'b0;
        won = 1'b0;
        if (it.op == CMD_CLEAR)
        begin
            edges_held = 0;
            foreach (vertex_uses[v])
                vertex_uses[v] = '0;
            return res;
        end
        res.uses = vertex_uses[it.from_vtx];
        for (e = 0; e < edges_held && !found; e++)
        begin
            if (edge_tbl[e].start_vtx == it.from_vtx && edge_tbl[e].end_vtx == it.to_vtx)
            begin
                res.code = mept_pkg::ST_SAME_DIR;
                found = 1'b1;
            end
            else if (edge_tbl[e].start_vtx == it.to_vtx && edge_tbl[e].end_vtx == it.from_vtx)
            begin
                found = 1'b1;
                if (edge_tbl[e].first_poly == it.poly)
                    res.code = mept_pkg::ST_SAME_POLY;
                else if (edge_tbl[e].owners > 2'd1)
                    res.code = mept_pkg::ST_THIRD;
                else
                begin
                    edge_tbl[e].owners = 2'd2;
                    edge_tbl[e].second_poly = it.poly;
                    edge_tbl[e].second_side = it.side;
                    res.code = mept_pkg::ST_PAIRED;
                    res.edge_idx = 10'(e);
                    res.dir = 1'b1;
                    won = 1'b1;
                end
            end
        end
        if (!found)
        begin
            if (edges_held >= mept_pkg::MAX_EDGES)
                res.code = mept_pkg::ST_FULL;
            else
            begin
                edge_tbl[edges_held] = '{it.from_vtx, it.to_vtx, it.poly, it.side,
                                         12'd0, 4'd0, 2'd1};
                res.code = mept_pkg::ST_NEW;
                res.edge_idx = 10'(edges_held);
                edges_held++;
                won = 1'b1;
            end
        end
        if (won)
        begin
            if (res.uses != 16'hFFFF)
                res.uses = res.uses + 16'd1;
            vertex_uses[it.from_vtx] = res.uses;
        end
        return res;
    endfunction

    function automatic drill_row_t drill_row(input logic op, input int vf, input int vt,
                                             input int p, input int s, input bit hand,
                                             input mept_pkg::status_t st, input int idx,
                                             input bit d, input int cnt);
        drill_row_t row;
        row.item = '{op, 10'(vf), 10'(vt), 12'(p), 4'(s)};
        row.hand_checked = hand;
        row.golden = '{st, 10'(idx), d, 16'(cnt)};
        return row;
    endfunction

    // Offer one side, hold it until the transfer, then log what it must produce.
    task automatic send_side(input side_item_t it, input bit hand, input outcome_t golden);
        outcome_t predicted;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            side_valid <= 1'b0;
            @(posedge clk);
        end
        side_valid  <= 1'b1;
        cmd         <= it.op;
        vertex_from <= it.from_vtx;
        vertex_to   <= it.to_vtx;
        polygon_id  <= it.poly;
        side_index  <= it.side;
        @(posedge clk);
        while (side_stall)
            @(posedge clk);
        predicted = resolve_side(it);
        pending_outcomes.push_back(hand ? golden : predicted);
    endtask

    task automatic wait_outcomes_done();
        side_valid <= 1'b0;
        @(posedge clk);
        while (pending_outcomes.size() != 0)
            @(posedge clk);
    endtask

    // Mostly whole polygons over a small vertex pool, so sides meet again both ways.
    task automatic random_segment(input int n_items);
        side_item_t  it;
        logic [9:0]  corner [16];
        logic [11:0] poly;
        bit          flip;
        int          sent;
        int          roll;
        int          k;
        int          j;
        sent = 0;
        clear_at = 0;
        while (sent < n_items)
        begin
            roll = $urandom_range(0, 99);
            if (edges_held >= clear_at || roll < 2)
            begin
                it = '{CMD_CLEAR, 10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)),
                       12'($urandom_range(0, 4095)), 4'($urandom_range(0, 15))};
                send_side(it, 1'b0, '0);
                sent++;
                foreach (vtx_pool[p])
                    vtx_pool[p] = 10'($urandom_range(0, 1023));
                clear_at = $urandom_range(8, 64);
            end
            else if (roll < 14)
            begin
                it.op = CMD_ADD;
                if (roll < 8)
                begin
                    it.from_vtx = vtx_pool[$urandom_range(0, POOL_SIZE - 1)];
                    it.to_vtx = vtx_pool[$urandom_range(0, POOL_SIZE - 1)];
                end
                else
                begin
                    it.from_vtx = 10'($urandom_range(0, 1023));
                    it.to_vtx = 10'($urandom_range(0, 1023));
                end
                it.poly = 12'($urandom_range(0, 4095));
                it.side = 4'($urandom_range(0, 15));
                send_side(it, 1'b0, '0);
                sent++;
            end
            else
            begin
                k = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 16) : $urandom_range(3, 6);
                for (j = 0; j < k; j++)
                    corner[j] = vtx_pool[$urandom_range(0, POOL_SIZE - 1)];
                poly = (roll < 20) ? last_poly : 12'($urandom_range(0, 4095));
                flip = ($urandom_range(0, 7) == 0);
                for (j = 0; j < k && sent < n_items; j++)
                begin
                    it.op = CMD_ADD;
                    it.from_vtx = flip ? corner[(j + 1) % k] : corner[j];
                    it.to_vtx = flip ? corner[j] : corner[(j + 1) % k];
                    it.poly = poly;
                    it.side = ($urandom_range(0, 15) == 0) ? 4'($urandom_range(0, 15)) : 4'(j);
                    send_side(it, 1'b0, '0);
                    sent++;
                end
                last_poly = poly;
            end
        end
    endtask

    // Receiver: random stalls, or one long hold-off when the stimulus asks for it.
    always @(posedge clk)
    begin
        if (holdoff_left > 0)
        begin
            result_stall <= 1'b1;
            holdoff_left <= holdoff_left - 1;
        end
        else if (holdoff_served != holdoff_asked)
        begin
            result_stall <= 1'b1;
            holdoff_served <= holdoff_served + 1;
            holdoff_left <= HOLDOFF_CYCLES;
        end
        else
            result_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            results_seen++;
            if (pending_outcomes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d unexpected: status %0d edge %0d rank %0d count %0d",
                             results_seen, status, edge_index, owner_rank,
                             vertex_use_count);
            end
            else
            begin
                want = pending_outcomes.pop_front();
                if (status !== want.code || edge_index !== want.edge_idx ||
                    owner_rank !== want.dir || vertex_use_count !== want.uses)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d: expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                                 results_seen, want.code, want.edge_idx, want.dir, want.uses,
                                 status, edge_index, owner_rank, vertex_use_count);
                end
            end
        end
    end

    initial
    begin
        for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++)
            @(posedge clk);
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        side_item_t it;
        int         n;
        rst_n        <= 1'b0;
        side_valid   <= 1'b0;
        cmd          <= CMD_ADD;
        vertex_from  <= '0;
        vertex_to    <= '0;
        polygon_id   <= '0;
        side_index   <= '0;
        foreach (vertex_uses[v])
            vertex_uses[v] = '0;

        drill[0]  = drill_row(CMD_ADD, 0, 1023, 0, 0, 1'b1,
                              mept_pkg::ST_NEW, 0, 1'b0, 1);
        drill[1]  = drill_row(CMD_ADD, 1023, 0, 4095, 15, 1'b1,
                              mept_pkg::ST_PAIRED, 0, 1'b1, 1);
        drill[2]  = drill_row(CMD_ADD, 1023, 0, 7, 3, 1'b1,
                              mept_pkg::ST_THIRD, 0, 1'b0, 1);
        drill[3]  = drill_row(CMD_ADD, 0, 1023, 9, 1, 1'b1,
                              mept_pkg::ST_SAME_DIR, 0, 1'b0, 1);
        drill[4]  = drill_row(CMD_ADD, 5, 6, 100, 1, 1'b0,
                              mept_pkg::ST_NEW, 0, 1'b0, 0);
        drill[5]  = drill_row(CMD_ADD, 6, 5, 100, 2, 1'b1,
                              mept_pkg::ST_SAME_POLY, 0, 1'b0, 0);
        drill[6]  = drill_row(CMD_ADD, 6, 5, 101, 0, 1'b0,
                              mept_pkg::ST_NEW, 0, 1'b0, 0);
        drill[7]  = drill_row(CMD_ADD, 7, 7, 200, 0, 1'b0,
                              mept_pkg::ST_NEW, 0, 1'b0, 0);
        drill[8]  = drill_row(CMD_ADD, 7, 7, 201, 1, 1'b1,
                              mept_pkg::ST_SAME_DIR, 0, 1'b0, 1);
        drill[9]  = drill_row(CMD_ADD, 682, 341, 2730, 10, 1'b0,
                              mept_pkg::ST_NEW, 0, 1'b0, 0);
        drill[10] = drill_row(CMD_ADD, 341, 682, 1365, 5, 1'b0,
                              mept_pkg::ST_NEW, 0, 1'b0, 0);
        drill[11] = drill_row(CMD_CLEAR, 1023, 1023, 4095, 15, 1'b1,
                              mept_pkg::ST_NEW, 0, 1'b0, 0);
        drill[12] = drill_row(CMD_ADD, 5, 6, 4095, 15, 1'b1,
                              mept_pkg::ST_NEW, 0, 1'b0, 1);
        drill[13] = drill_row(CMD_ADD, 1023, 1023, 4095, 15, 1'b0,
                              mept_pkg::ST_NEW, 0, 1'b0, 0);
        drill[14] = drill_row(CMD_ADD, 6, 5, 4095, 0, 1'b1,
                              mept_pkg::ST_SAME_POLY, 0, 1'b0, 0);
        drill[15] = drill_row(CMD_ADD, 6, 5, 0, 0, 1'b0,
                              mept_pkg::ST_NEW, 0, 1'b0, 0);
        drill[16] = drill_row(CMD_CLEAR, 0, 0, 0, 0, 1'b1,
                              mept_pkg::ST_NEW, 0, 1'b0, 0);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 11;
        recv_idle_pct = 83;
        for (n = 0; n < N_DRILL; n++)
            send_side(drill[n].item, drill[n].hand_checked, drill[n].golden);
        wait_outcomes_done();
        random_segment(350);
        wait_outcomes_done();

        send_idle_pct = 83;
        recv_idle_pct = 11;
        random_segment(300);
        wait_outcomes_done();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_segment(300);

        // Fill every edge slot with a distinct chain edge, then probe the full table.
        it = '{CMD_CLEAR, 10'd0, 10'd0, 12'd0, 4'd0};
        send_side(it, 1'b0, '0);
        for (n = 0; n < mept_pkg::MAX_EDGES; n++)
        begin
            // Hold results back while sides keep coming, so the input backs up.
            if (n == 64)
                holdoff_asked++;
            it = '{CMD_ADD, 10'(n), 10'(n + 1), 12'(n), 4'(n)};
            send_side(it, 1'b0, '0);
        end
        it = '{CMD_ADD, 10'd5, 10'd900, 12'd17, 4'd2};
        send_side(it, 1'b0, '0);
        it = '{CMD_ADD, 10'd1, 10'd0, 12'd4095, 4'd15};
        send_side(it, 1'b0, '0);
        it = '{CMD_ADD, 10'd1023, 10'd0, 12'd3, 4'd7};
        send_side(it, 1'b0, '0);
        wait_outcomes_done();

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_outcomes.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
